/* hdl/ghash_block_accumulator_defines.svh */
// assertion macros for the ghash block accumulator checker
// no dependencies; included by files that carry assertions
`ifndef GHASH_BLOCK_ACCUMULATOR_DEFINES_SVH
`define GHASH_BLOCK_ACCUMULATOR_DEFINES_SVH

// implication into the next cycle, held off during reset
`define GHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ghb assertion failed");

// implication in the same cycle, held off during reset
`define GHB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ghb assertion failed");

`endif

/* hdl/ghb_pkg.sv */
// shared types, constants and gf(2^128) helpers for the ghash block accumulator
// no dependencies
`default_nettype none

package ghb_pkg;

    // default digit width of the serial multiplier
    localparam int DIGIT_BITS_DEF = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_HI = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_LO = 8'd1;

    // reduction constant in the reflected gcm convention
    localparam logic [63:0] POLY_HI = 64'he100000000000000;

    // control from the top level to the multiplier
    typedef struct packed {
        logic load;
        logic ack;
    } t_mult_ctl;

    // status from the multiplier to the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_mult_stat;

    // multiply by x with reduction, msb of the word is the x^0 term
    function automatic logic [127:0] times_x(input logic [127:0] v);
        logic [127:0] r;
        r = v >> 1;
        r[127:64] = r[127:64] ^ (v[0] ? POLY_HI : 64'd0);
        return r;
    endfunction

    // upper half of v * x^digit_bits, used to fold shifted-out bits back
    function automatic logic [63:0] fold_entry(input int v, input int digit_bits);
        logic [127:0] r;
        r = {96'd0, v};
        for (int j = 0; j < digit_bits; j++) begin
            r = times_x(r);
        end
        return r[127:64];
    endfunction

endpackage

`default_nettype wire

/* hdl/ghb_ifs.sv */
// valid/ready channel interfaces of the ghash block accumulator
// uses ghb_pkg for the configuration index width
`default_nettype none

// data block channel
interface ghb_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic        start_req;

    modport source (output valid, output block_hi, output block_lo, output start_req,
                    input ready);
    modport sink   (input valid, input block_hi, input block_lo, input start_req,
                    output ready);
endinterface

// digest channel
interface ghb_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_hi;
    logic [63:0] digest_lo;

    modport source (output valid, output digest_hi, output digest_lo, input ready);
    modport sink   (input valid, input digest_hi, input digest_lo, output ready);
endinterface

// configuration write channel
interface ghb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ghb_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [63:0]                    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

/* hdl/ghash_block_accumulator.sv */
// ghash block accumulator top level: key registers, accumulator, digest register
// uses ghb_pkg, ghb_ifs, ghb_key_powers and ghb_digit_mult
//
// channel  direction  payload                        accepted when
// i_blk    in         block_hi, block_lo, start_req  valid && ready
// o_dig    out        digest_hi, digest_lo           valid && ready
// i_cfg    in         reg_index, wr_data             valid && ready
//
// an item passes through one load, one digit per cycle in the digit loop of
// ghb_digit_mult, and one write-back before the next block can be accepted;
// the write-back waits while the digest register still holds an untaken digest.
// after reset and after each key write, blocks wait while the power taps refill.
// a digest that is not taken holds the result in the digest register, and the
// next block may be accepted meanwhile.
`default_nettype none

module ghash_block_accumulator #(
    parameter int DIGIT_BITS = ghb_pkg::DIGIT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ghb_blk_if.sink    i_blk,
    ghb_dig_if.source  o_dig,
    ghb_cfg_if.sink    i_cfg
);

    logic [63:0]                  r_key_hi;
    logic [63:0]                  r_key_lo;
    logic [127:0]                 r_acc;
    logic [127:0]                 r_out;
    logic                         r_out_valid;

    logic                         w_cfg_acc;
    logic                         w_key_wr;
    logic [DIGIT_BITS-1:0][127:0] w_powers;
    logic                         w_settled;
    logic [127:0]                 w_operand;
    logic [127:0]                 w_prod;
    ghb_pkg::t_mult_ctl           w_ctl;
    ghb_pkg::t_mult_stat          w_stat;

    // key registers
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_key_wr    = w_cfg_acc && ((i_cfg.reg_index == ghb_pkg::REG_HASH_KEY_HI) ||
                                       (i_cfg.reg_index == ghb_pkg::REG_HASH_KEY_LO));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.reg_index)
                ghb_pkg::REG_HASH_KEY_HI: r_key_hi <= i_cfg.wr_data;
                ghb_pkg::REG_HASH_KEY_LO: r_key_lo <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    ghb_key_powers #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_key_powers (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     ({r_key_hi, r_key_lo}),
        .i_key_wr  (w_key_wr),
        .o_powers  (w_powers),
        .o_settled (w_settled)
    );

    // block intake: start clears the running value before the xor
    assign i_blk.ready = w_stat.idle && w_settled;
    assign w_operand   = (i_blk.start_req ? 128'd0 : r_acc) ^ {i_blk.block_hi, i_blk.block_lo};
    assign w_ctl.load  = i_blk.valid && i_blk.ready;
    assign w_ctl.ack   = w_stat.done && (!r_out_valid || o_dig.ready);

    ghb_digit_mult #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_digit_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_operand (w_operand),
        .i_powers  (w_powers),
        .o_stat    (w_stat),
        .o_prod    (w_prod)
    );

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_ctl.ack) begin
            r_acc <= w_prod;
        end
    end

    // digest register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.ack) begin
            r_out_valid <= 1'b1;
        end else if (o_dig.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ack) begin
            r_out <= w_prod;
        end
    end

    assign o_dig.valid     = r_out_valid;
    assign o_dig.digest_hi = r_out[127:64];
    assign o_dig.digest_lo = r_out[63:0];

endmodule

`default_nettype wire

/* hdl/ghb_key_powers.sv */
// shift line of key powers h, h*x, ... h*x^(digit_bits-1)
// uses ghb_pkg::times_x
`default_nettype none

module ghb_key_powers #(
    parameter int DIGIT_BITS = ghb_pkg::DIGIT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [127:0]                 i_key,
    input  wire logic                         i_key_wr,
    output logic [DIGIT_BITS-1:0][127:0]      o_powers,
    output logic                              o_settled
);

    localparam int SW = $clog2(DIGIT_BITS + 1);

    logic [DIGIT_BITS-1:0][127:0] r_pow;
    logic [SW-1:0]                r_settle;
    logic [SW-1:0]                n_settle;

    // each tap takes the previous one times x, the line refills after a key change
    always_ff @(posedge i_clk) begin
        r_pow[0] <= i_key;
        for (int j = 1; j < DIGIT_BITS; j++) begin
            r_pow[j] <= ghb_pkg::times_x(r_pow[j-1]);
        end
    end

    // settle count: the line is valid once every tap has seen the key
    always_comb begin
        n_settle = r_settle;
        if (i_key_wr) begin
            n_settle = SW'(DIGIT_BITS);
        end else if (r_settle != '0) begin
            n_settle = r_settle - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SW'(DIGIT_BITS);
        end else begin
            r_settle <= n_settle;
        end
    end

    assign o_powers  = r_pow;
    assign o_settled = (r_settle == '0);

endmodule

`default_nettype wire

/* hdl/ghb_digit_mult.sv */
// digit-serial gf(2^128) multiplier, one digit of the operand per cycle
// uses ghb_pkg types and fold_entry; key powers come from ghb_key_powers
`default_nettype none

module ghb_digit_mult #(
    parameter int DIGIT_BITS = ghb_pkg::DIGIT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ghb_pkg::t_mult_ctl           i_ctl,
    input  wire logic [127:0]                 i_operand,
    input  wire logic [DIGIT_BITS-1:0][127:0] i_powers,
    output ghb_pkg::t_mult_stat               o_stat,
    output logic [127:0]                      o_prod
);

    localparam int NUM_DIGITS = (128 + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int XW         = NUM_DIGITS * DIGIT_BITS;
    localparam int PADW       = XW - 128;
    localparam int TBL        = 1 << DIGIT_BITS;
    localparam int CW         = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [XW-1:0]        r_x, n_x;
    logic [127:0]         r_z, n_z;

    logic [63:0]          w_fold [TBL];
    logic [DIGIT_BITS-1:0] w_digit;
    logic [DIGIT_BITS-1:0] w_rem;
    logic [127:0]         w_mul;
    logic [127:0]         w_step;

    // constant reduction table for the bits that drop off the low end
    for (genvar v = 0; v < TBL; v++) begin : g_fold
        localparam logic [63:0] FOLD_V = ghb_pkg::fold_entry(v, DIGIT_BITS);
        assign w_fold[v] = FOLD_V;
    end

    // last digit first: it sits at the bottom of the operand shift register
    assign w_digit = r_x[DIGIT_BITS-1:0];
    assign w_rem   = r_z[DIGIT_BITS-1:0];

    // digit times h from the power taps, msb of the digit picks h itself
    always_comb begin
        w_mul = '0;
        for (int j = 0; j < DIGIT_BITS; j++) begin
            if (w_digit[DIGIT_BITS-1-j]) begin
                w_mul = w_mul ^ i_powers[j];
            end
        end
    end

    // horner step: z * x^digit_bits plus digit * h
    assign w_step = (r_z >> DIGIT_BITS) ^ {w_fold[w_rem], 64'd0} ^ w_mul;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_z     = r_z;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.load) begin
                    n_x     = XW'(i_operand) << PADW;
                    n_z     = '0;
                    n_cnt   = CW'(NUM_DIGITS);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_z   = w_step;
                n_x   = r_x >> DIGIT_BITS;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_z <= n_z;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_prod      = r_z;

endmodule

`default_nettype wire

/* hdl/ghb_checker.sv */
// port-level checker for the ghash block accumulator, bound to the top level
// uses ghash_block_accumulator_defines.svh and ghb_pkg register indexes
`default_nettype none

`include "ghash_block_accumulator_defines.svh"

module ghb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_blk_valid,
    input wire logic                          i_blk_ready,
    input wire logic                          i_dig_valid,
    input wire logic                          i_dig_ready,
    input wire logic [63:0]                   i_digest_hi,
    input wire logic [63:0]                   i_digest_lo,
    input wire logic                          i_cfg_valid,
    input wire logic                          i_cfg_ready,
    input wire logic [ghb_pkg::CFG_IDX_W-1:0] i_cfg_index
);

    logic w_key_wr;

    // only key register writes refill the power taps
    assign w_key_wr = i_cfg_valid && i_cfg_ready &&
                      ((i_cfg_index == ghb_pkg::REG_HASH_KEY_HI) ||
                       (i_cfg_index == ghb_pkg::REG_HASH_KEY_LO));

    // one block in flight: intake closes right after an accept
    `GHB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_blk_valid && i_blk_ready, !i_blk_ready)

    // a key write holds off blocks while the power taps refill
    `GHB_ASSERT_NEXT(a_key_refill, i_clk, i_rst_n, w_key_wr, !i_blk_ready)

    // a waiting digest holds its value
    `GHB_ASSERT_NEXT(a_dig_hold, i_clk, i_rst_n, i_dig_valid && !i_dig_ready,
        i_dig_valid && $stable(i_digest_hi) && $stable(i_digest_lo))

    // a digest never appears in the cycle right after its block is taken
    `GHB_ASSERT_SAME(a_no_early_dig, i_clk, i_rst_n, $rose(i_dig_valid),
        !$past(i_blk_valid && i_blk_ready))

endmodule

bind ghash_block_accumulator ghb_checker u_ghb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_blk_valid (i_blk.valid),
    .i_blk_ready (i_blk.ready),
    .i_dig_valid (o_dig.valid),
    .i_dig_ready (o_dig.ready),
    .i_digest_hi (o_dig.digest_hi),
    .i_digest_lo (o_dig.digest_lo),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.reg_index)
);

`default_nettype wire
